// File: hw/rtl/vts_pkg.sv
// Package with shared widths, character codes and helper functions of the scanner.
`default_nettype none
package vts_pkg;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int NUM_W = 32;
  localparam int HASH_W = 64;
  localparam int IDX_W = 2;
  localparam int BYTES_PER_WORD = 8;
  localparam int OUT_WORDS = 4;
  localparam int HASH_BYTES_DEF = 32;

  localparam logic [NUM_W-1:0] SAT32 = 32'hFFFF_FFFF;

  // Characters of the token.
  localparam logic [BYTE_W-1:0] CH_V = 8'h56;
  localparam logic [BYTE_W-1:0] CH_L = 8'h4C;
  localparam logic [BYTE_W-1:0] CH_H = 8'h48;
  localparam logic [BYTE_W-1:0] CH_W = 8'h57;
  localparam logic [BYTE_W-1:0] CH_DOT = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9 = 8'h39;
  localparam logic [BYTE_W-1:0] CH_A_LC = 8'h61;
  localparam logic [BYTE_W-1:0] CH_F_LC = 8'h66;

  // Multiply by ten, add one digit, saturate at the top of 32 bits.
  function automatic logic [NUM_W-1:0] acc_digit(input logic [NUM_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b);
    logic [NUM_W+3:0] t;
    logic [BYTE_W-1:0] d;
    d = b - CH_0;
    t = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + {{(NUM_W-4){1'b0}}, d};
    return (|t[NUM_W+3:NUM_W]) ? SAT32 : t[NUM_W-1:0];
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  // Hex digit value; bit 4 set means the byte is not a lowercase hex digit.
  function automatic logic [4:0] nibble_of(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] t;
    t = 8'h00;
    if ((b >= CH_0) && (b <= CH_9)) begin
      t = b - CH_0;
      return {1'b0, t[3:0]};
    end else if ((b >= CH_A_LC) && (b <= CH_F_LC)) begin
      t = b - CH_A_LC + 8'd10;
      return {1'b0, t[3:0]};
    end
    return 5'h10;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/vts_ifs.sv
// Valid/ready channel interfaces for the scanner's byte input and result output.
`default_nettype none
interface vts_in_if;
  logic valid;
  logic ready;
  logic [vts_pkg::BYTE_W-1:0] data_byte;
  logic end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface vts_out_if;
  logic valid;
  logic ready;
  logic found;
  logic [vts_pkg::NUM_W-1:0] version_number;
  logic [vts_pkg::NUM_W-1:0] image_size;
  logic [vts_pkg::NUM_W-1:0] wait_time;
  logic [vts_pkg::HASH_W-1:0] hash_word;
  logic [vts_pkg::IDX_W-1:0] word_index;
  logic last_result;

  modport source (output valid, output found, output version_number, output image_size,
                  output wait_time, output hash_word, output word_index,
                  output last_result, input ready);
  modport sink (input valid, input found, input version_number, input image_size,
                input wait_time, input hash_word, input word_index,
                input last_result, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/version_token_scanner_unit.sv
// Version token scanner: byte parser, hash memory and result word emitter.
// Throughput: one byte a cycle. Input stalls only while the words of a result are still
// being read from the hash memory and the next byte could write the memory or start a result.
// The byte that ends the token loads the emitter; the first row read is then issued, its data
// is registered in the read stage, and the word passes on into the output register.
// A found token gives four words on consecutive cycles when the sink is ready.
// Reset (rst_n low, synchronous) clears the parser, the emitter and the output valid;
// the hash memory is not cleared, since every byte is written before it is read.
`default_nettype none
module version_token_scanner_unit #(
  parameter int HASH_BYTES = vts_pkg::HASH_BYTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  vts_in_if.sink    in_chan,
  vts_out_if.source out_chan
);

  localparam int HASH_WORDS = (HASH_BYTES + vts_pkg::BYTES_PER_WORD - 1)
                              / vts_pkg::BYTES_PER_WORD;
  localparam int RW = (HASH_WORDS > 1) ? $clog2(HASH_WORDS) : 1;
  localparam int HPOS_W = $clog2(2 * HASH_BYTES + 1);
  localparam int BIDX_W = HPOS_W - 1;
  localparam logic [HPOS_W-1:0] HEX_END = HPOS_W'(2 * HASH_BYTES);

  // Parse phases.
  localparam logic [3:0] PH_SEARCH = 4'd0;
  localparam logic [3:0] PH_V      = 4'd1;
  localparam logic [3:0] PH_VDIG   = 4'd2;
  localparam logic [3:0] PH_CL     = 4'd3;
  localparam logic [3:0] PH_L      = 4'd4;
  localparam logic [3:0] PH_LDIG   = 4'd5;
  localparam logic [3:0] PH_CH     = 4'd6;
  localparam logic [3:0] PH_H      = 4'd7;
  localparam logic [3:0] PH_HEX    = 4'd8;
  localparam logic [3:0] PH_AFTER  = 4'd9;
  localparam logic [3:0] PH_CW     = 4'd10;
  localparam logic [3:0] PH_W      = 4'd11;
  localparam logic [3:0] PH_WDIG   = 4'd12;

  localparam int NW = vts_pkg::NUM_W;
  localparam int BW = vts_pkg::BYTE_W;

  // Parser state.
  logic [3:0]        phase_r, phase_nxt;
  logic [NW-1:0]     ver_r, ver_nxt;
  logic [NW-1:0]     size_r, size_nxt;
  logic [NW-1:0]     wait_r, wait_nxt;
  logic [HPOS_W-1:0] hpos_r, hpos_nxt;
  logic [3:0]        hnib_r, hnib_nxt;
  logic              dseen_r, dseen_nxt;
  logic              mdone_r, mdone_nxt;

  // Emitter state: captured numbers, words left to read, read stage.
  logic          cap_found_r;
  logic [NW-1:0] cap_ver_r, cap_size_r, cap_wait_r;
  logic [2:0]    left_r;
  logic [1:0]    iss_k_r;
  logic          rd_vld_r, rd_last_r;
  logic [1:0]    rd_k_r;
  logic [vts_pkg::HASH_W-1:0] rd_data_r;

  // Output register.
  logic          out_valid_r, out_found_r, out_last_r;
  logic [NW-1:0] out_ver_r, out_size_r, out_wait_r;
  logic [vts_pkg::HASH_W-1:0] out_hash_r;
  logic [1:0]    out_k_r;

  // Hash memory, one row per eight-byte word.
  logic [vts_pkg::HASH_W-1:0] hash_mem [HASH_WORDS];

  logic          in_acc, busy;
  logic [BW-1:0] b;
  logic          last;
  logic [4:0]    nib;
  logic [3:0]    restart_ph;
  logic          emit_sw, trig_found, trig_nf, wr_en;
  logic [NW-1:0] cap_ver_d, cap_size_d, cap_wait_d;
  logic [BIDX_W-1:0] wr_bidx;
  logic [RW-1:0] wr_row, rd_addr;
  logic [2:0]    wr_lane;
  logic          iss, rd_adv;
  logic [vts_pkg::HASH_W-1:0] hash_masked;

  assign b = in_chan.data_byte;
  assign last = in_chan.end_of_buffer;
  assign busy = (left_r != 3'd0) || rd_vld_r;

  // Hold input while earlier words are still read and this byte could write or emit.
  assign in_chan.ready = !(busy && !mdone_r &&
                           ((phase_r inside {[PH_HEX:PH_WDIG]}) || last));
  assign in_acc = in_chan.valid && in_chan.ready;

  assign nib = vts_pkg::nibble_of(b);
  assign restart_ph = (b == vts_pkg::CH_V) ? PH_V : PH_SEARCH;

  // Token parser: next phase and accumulators for one accepted byte.
  always_comb begin
    phase_nxt = phase_r;
    ver_nxt = ver_r;
    size_nxt = size_r;
    wait_nxt = wait_r;
    hpos_nxt = hpos_r;
    hnib_nxt = hnib_r;
    dseen_nxt = dseen_r;
    mdone_nxt = mdone_r;
    emit_sw = 1'b0;
    wr_en = 1'b0;
    trig_found = 1'b0;
    trig_nf = 1'b0;
    cap_ver_d = ver_r;
    cap_size_d = size_r;
    cap_wait_d = wait_r;
    if (in_acc) begin
      if (!mdone_r) begin
        case (phase_r)
          PH_SEARCH: phase_nxt = restart_ph;
          PH_V: begin
            if (b == vts_pkg::CH_DOT) begin
              phase_nxt = PH_VDIG;
              ver_nxt = '0;
              dseen_nxt = 1'b0;
            end else begin
              phase_nxt = restart_ph;
            end
          end
          PH_VDIG: begin
            if (vts_pkg::is_digit(b)) begin
              ver_nxt = vts_pkg::acc_digit(ver_r, b);
              dseen_nxt = 1'b1;
            end else if ((b == vts_pkg::CH_COLON) && dseen_r) begin
              phase_nxt = PH_CL;
            end else begin
              phase_nxt = restart_ph;
            end
          end
          PH_CL: phase_nxt = (b == vts_pkg::CH_L) ? PH_L : restart_ph;
          PH_L: begin
            if (b == vts_pkg::CH_DOT) begin
              phase_nxt = PH_LDIG;
              size_nxt = '0;
            end else begin
              phase_nxt = restart_ph;
            end
          end
          PH_LDIG: begin
            if (vts_pkg::is_digit(b)) begin
              size_nxt = vts_pkg::acc_digit(size_r, b);
            end else if (b == vts_pkg::CH_COLON) begin
              phase_nxt = PH_CH;
            end else begin
              phase_nxt = restart_ph;
            end
          end
          PH_CH: phase_nxt = (b == vts_pkg::CH_H) ? PH_H : restart_ph;
          PH_H: begin
            if (b == vts_pkg::CH_DOT) begin
              phase_nxt = PH_HEX;
              hpos_nxt = '0;
            end else begin
              phase_nxt = restart_ph;
            end
          end
          PH_HEX: begin
            if (nib[4]) begin
              phase_nxt = restart_ph;
            end else begin
              if (!hpos_r[0]) begin
                hnib_nxt = nib[3:0];
              end else begin
                wr_en = 1'b1;
              end
              hpos_nxt = hpos_r + 1'b1;
              if (hpos_nxt == HEX_END) begin
                phase_nxt = PH_AFTER;
                wait_nxt = '0;
              end
            end
          end
          PH_AFTER: begin
            if (b == vts_pkg::CH_COLON) begin
              phase_nxt = PH_CW;
            end else begin
              emit_sw = 1'b1;
            end
          end
          PH_CW: begin
            if (b == vts_pkg::CH_W) begin
              phase_nxt = PH_W;
            end else begin
              emit_sw = 1'b1;
            end
          end
          PH_W: begin
            if (b == vts_pkg::CH_DOT) begin
              phase_nxt = PH_WDIG;
              wait_nxt = '0;
            end else begin
              emit_sw = 1'b1;
            end
          end
          PH_WDIG: begin
            if (vts_pkg::is_digit(b)) begin
              wait_nxt = vts_pkg::acc_digit(wait_r, b);
            end else begin
              emit_sw = 1'b1;
            end
          end
          default: phase_nxt = PH_SEARCH;
        endcase
      end
      if (emit_sw) begin
        mdone_nxt = 1'b1;
      end
      // The end of the buffer completes a pending match or reports not found.
      trig_found = emit_sw ||
                   (last && !mdone_nxt && (phase_nxt inside {[PH_AFTER:PH_WDIG]}));
      trig_nf = last && !mdone_nxt && !(phase_nxt inside {[PH_AFTER:PH_WDIG]});
      cap_ver_d = ver_nxt;
      cap_size_d = size_nxt;
      cap_wait_d = wait_nxt;
      if (last) begin
        phase_nxt = PH_SEARCH;
        mdone_nxt = 1'b0;
        dseen_nxt = 1'b0;
        hpos_nxt = '0;
        hnib_nxt = '0;
        ver_nxt = '0;
        size_nxt = '0;
        wait_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      ver_r <= '0;
      size_r <= '0;
      wait_r <= '0;
      hpos_r <= '0;
      hnib_r <= '0;
      dseen_r <= 1'b0;
      mdone_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      ver_r <= ver_nxt;
      size_r <= size_nxt;
      wait_r <= wait_nxt;
      hpos_r <= hpos_nxt;
      hnib_r <= hnib_nxt;
      dseen_r <= dseen_nxt;
      mdone_r <= mdone_nxt;
    end
  end

  // Hash memory write: one byte lane of a row, first byte in the top lane.
  assign wr_bidx = hpos_r[HPOS_W-1:1];
  assign wr_row = RW'(wr_bidx >> 3);
  assign wr_lane = wr_bidx[2:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hash_mem[wr_row][(3'd7 - wr_lane) * BW +: BW] <= {hnib_r, nib[3:0]};
    end
  end

  // Word emitter: issue one row read a cycle while the read stage can take it.
  assign rd_adv = rd_vld_r && (!out_valid_r || out_chan.ready);
  assign iss = (left_r != 3'd0) && (!rd_vld_r || rd_adv);
  assign rd_addr = (int'(iss_k_r) < HASH_WORDS) ? iss_k_r[RW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (iss) begin
      rd_data_r <= hash_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 3'd0;
      iss_k_r <= 2'd0;
      rd_vld_r <= 1'b0;
      rd_k_r <= 2'd0;
      rd_last_r <= 1'b0;
    end else begin
      if (trig_found || trig_nf) begin
        left_r <= trig_found ? 3'(vts_pkg::OUT_WORDS) : 3'd1;
        iss_k_r <= 2'd0;
      end else if (iss) begin
        left_r <= left_r - 3'd1;
        iss_k_r <= iss_k_r + 2'd1;
      end
      if (iss) begin
        rd_vld_r <= 1'b1;
        rd_k_r <= iss_k_r;
        rd_last_r <= (left_r == 3'd1);
      end else if (rd_adv) begin
        rd_vld_r <= 1'b0;
      end
    end
  end

  // Captured numbers stay put until the last word has left the read stage.
  always_ff @(posedge clk) begin
    if (trig_found || trig_nf) begin
      cap_found_r <= trig_found;
      cap_ver_r <= trig_found ? cap_ver_d : '0;
      cap_size_r <= trig_found ? cap_size_d : '0;
      cap_wait_r <= trig_found ? cap_wait_d : '0;
    end
  end

  // Bytes beyond the hash length read as zero; a not-found word carries no hash.
  always_comb begin
    hash_masked = '0;
    for (int j = 0; j < vts_pkg::BYTES_PER_WORD; j++) begin
      if (cap_found_r && (int'(rd_k_r) * vts_pkg::BYTES_PER_WORD + j < HASH_BYTES)) begin
        hash_masked[(7 - j) * BW +: BW] = rd_data_r[(7 - j) * BW +: BW];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_adv) begin
      out_found_r <= cap_found_r;
      out_ver_r <= cap_ver_r;
      out_size_r <= cap_size_r;
      out_wait_r <= cap_wait_r;
      out_hash_r <= hash_masked;
      out_k_r <= rd_k_r;
      out_last_r <= rd_last_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.found = out_found_r;
  assign out_chan.version_number = out_ver_r;
  assign out_chan.image_size = out_size_r;
  assign out_chan.wait_time = out_wait_r;
  assign out_chan.hash_word = out_hash_r;
  assign out_chan.word_index = out_k_r;
  assign out_chan.last_result = out_last_r;

endmodule
`default_nettype wire

// File: hw/rtl/vts_checker.sv
// Port-level checks on the scanner's result channel, bound to the scanner unit.
`default_nettype none
module vts_checker #(
  parameter int HASH_BYTES = vts_pkg::HASH_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic found,
  input wire logic [vts_pkg::NUM_W-1:0] version_number,
  input wire logic [vts_pkg::NUM_W-1:0] image_size,
  input wire logic [vts_pkg::NUM_W-1:0] wait_time,
  input wire logic [vts_pkg::HASH_W-1:0] hash_word,
  input wire logic [vts_pkg::IDX_W-1:0] word_index,
  input wire logic last_result
);

  // A stalled word stays on the channel.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hash_word) && $stable(word_index))
    else $error("result word dropped or changed while stalled");

  // A not-found word is a single, final, all-zero word.
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> last_result && word_index == 2'd0 && hash_word == '0 &&
                            version_number == '0 && image_size == '0 && wait_time == '0)
    else $error("not-found word carries data");

  // A found token ends exactly on its fourth word.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found |-> last_result == (word_index == 2'd3))
    else $error("last word flag does not match word index");

  // Within one found token the words follow in order.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && found && !last_result ##1 out_valid |->
      found && word_index == $past(word_index) + 2'd1)
    else $error("found words out of order");

  // With a short hash the last word carries no hash bytes.
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && found && word_index == 2'd3 && (HASH_BYTES <= 24) |-> hash_word == '0)
    else $error("hash bytes beyond the hash length are not zero");

endmodule

bind version_token_scanner_unit vts_checker #(.HASH_BYTES(HASH_BYTES)) u_vts_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .found(out_chan.found),
  .version_number(out_chan.version_number),
  .image_size(out_chan.image_size),
  .wait_time(out_chan.wait_time),
  .hash_word(out_chan.hash_word),
  .word_index(out_chan.word_index),
  .last_result(out_chan.last_result)
);
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the version token scanner: directed buffers, random traffic, stalls.
module tb_top;
  import vts_pkg::*;

  localparam int HASH_BYTES = HASH_BYTES_DEF;
  localparam int CLK_PERIOD = 12;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_GAP = 40;
  localparam int HOLD_CYCLES = 400;

  // Parse phases of the scanner, in token order.
  typedef enum logic [3:0] {
    SEEK_V, GOT_V, VER_DIGITS, WANT_L, GOT_L, SIZE_DIGITS, WANT_H, GOT_H, HASH_DIGITS,
    AFTER_HASH, WANT_W, GOT_W, WAIT_DIGITS
  } scan_phase_e;

  typedef struct packed {
    logic found;
    logic [NUM_W-1:0] version_number;
    logic [NUM_W-1:0] image_size;
    logic [NUM_W-1:0] wait_time;
    logic [HASH_W-1:0] hash_word;
    logic [IDX_W-1:0] word_index;
    logic last_result;
  } scan_result_t;

  logic clk;
  logic rst_n;

  vts_in_if in_if ();
  vts_out_if out_if ();

  version_token_scanner_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Scanner state as the testbench predicts it.
  scan_phase_e scan_phase = SEEK_V;
  logic [NUM_W-1:0] ver_acc = '0;
  logic [NUM_W-1:0] size_acc = '0;
  logic [NUM_W-1:0] wait_acc = '0;
  logic [BYTE_W-1:0] hash_mem [HASH_BYTES_DEF];
  logic [6:0] nib_count = '0;
  logic [3:0] upper_nib = '0;
  logic ver_has_digit = 1'b0;
  logic token_done = 1'b0;

  // Result words still owed by the block, oldest first.
  scan_result_t pending_results[$];

  int mismatches = 0;
  int words_sent = 0;
  int parsed_words = 0;
  int buffers_sent = 0;
  int results_predicted = 0;
  int found_seen = 0;
  int not_found_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;

  // Buffer under construction and the hash it carries.
  logic [BYTE_W-1:0] frame_q[$];
  logic [BYTE_W-1:0] token_hash [HASH_BYTES_DEF];

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("%0t: timeout, %0d result words still expected", $time, pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  // Decimal digit shifted into a saturating 32-bit accumulator.
  function automatic logic [NUM_W-1:0] dec_shift_in(input logic [NUM_W-1:0] acc,
                                                    input logic [BYTE_W-1:0] b);
    logic [63:0] t;
    logic [BYTE_W-1:0] d;
    d = b - CH_0;
    t = {32'd0, acc} * 64'd10 + {56'd0, d};
    return (t > {32'd0, SAT32}) ? SAT32 : t[NUM_W-1:0];
  endfunction

  function automatic logic is_dec_char(input logic [BYTE_W-1:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  // Lowercase hex value; bit 4 flags a byte that is not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] b);
    if (is_dec_char(b)) return {1'b0, b[3:0]};
    if ((b >= CH_A_LC) && (b <= CH_F_LC)) return {1'b0, b[3:0] + 4'd9};
    return 5'h10;
  endfunction

  // A failing byte is looked at again as the start of a new token.
  function automatic scan_phase_e restart_on(input logic [BYTE_W-1:0] b);
    return (b == CH_V) ? GOT_V : SEEK_V;
  endfunction

  function automatic void emit_token();
    logic [HASH_W-1:0] w;
    scan_result_t r;
    for (int k = 0; k < OUT_WORDS; k++) begin
      w = '0;
      for (int j = 0; j < BYTES_PER_WORD; j++) begin
        w = {w[HASH_W-9:0], (k * 8 + j < HASH_BYTES) ? hash_mem[k * 8 + j] : 8'h00};
      end
      r.found = 1'b1;
      r.version_number = ver_acc;
      r.image_size = size_acc;
      r.wait_time = wait_acc;
      r.hash_word = w;
      r.word_index = IDX_W'(k);
      r.last_result = (k == OUT_WORDS - 1);
      pending_results.push_back(r);
    end
    results_predicted += OUT_WORDS;
    token_done = 1'b1;
  endfunction

  function automatic void emit_not_found();
    scan_result_t r;
    r = '0;
    r.last_result = 1'b1;
    pending_results.push_back(r);
    results_predicted++;
  endfunction

  // Advances the predicted scanner by one accepted input word.
  function automatic void predict_word(input logic [BYTE_W-1:0] b, input logic eob);
    logic [4:0] nib;
    nib = hex_nibble(b);
    if (!token_done) begin
      case (scan_phase)
        SEEK_V: scan_phase = restart_on(b);
        GOT_V: begin
          if (b == CH_DOT) begin
            scan_phase = VER_DIGITS;
            ver_acc = '0;
            ver_has_digit = 1'b0;
          end else scan_phase = restart_on(b);
        end
        VER_DIGITS: begin
          if (is_dec_char(b)) begin
            ver_acc = dec_shift_in(ver_acc, b);
            ver_has_digit = 1'b1;
          end else if (b == CH_COLON && ver_has_digit) scan_phase = WANT_L;
          else scan_phase = restart_on(b);
        end
        WANT_L: scan_phase = (b == CH_L) ? GOT_L : restart_on(b);
        GOT_L: begin
          if (b == CH_DOT) begin
            scan_phase = SIZE_DIGITS;
            size_acc = '0;
          end else scan_phase = restart_on(b);
        end
        SIZE_DIGITS: begin
          if (is_dec_char(b)) size_acc = dec_shift_in(size_acc, b);
          else if (b == CH_COLON) scan_phase = WANT_H;
          else scan_phase = restart_on(b);
        end
        WANT_H: scan_phase = (b == CH_H) ? GOT_H : restart_on(b);
        GOT_H: begin
          if (b == CH_DOT) begin
            scan_phase = HASH_DIGITS;
            nib_count = '0;
          end else scan_phase = restart_on(b);
        end
        HASH_DIGITS: begin
          if (nib[4]) scan_phase = restart_on(b);
          else begin
            if (!nib_count[0]) upper_nib = nib[3:0];
            else hash_mem[nib_count[5:1]] = {upper_nib, nib[3:0]};
            nib_count = nib_count + 7'd1;
            if (nib_count >= 2 * HASH_BYTES) begin
              scan_phase = AFTER_HASH;
              wait_acc = '0;
            end
          end
        end
        AFTER_HASH: begin
          if (b == CH_COLON) scan_phase = WANT_W;
          else emit_token();
        end
        WANT_W: begin
          if (b == CH_W) scan_phase = GOT_W;
          else emit_token();
        end
        GOT_W: begin
          if (b == CH_DOT) begin
            scan_phase = WAIT_DIGITS;
            wait_acc = '0;
          end else emit_token();
        end
        WAIT_DIGITS: begin
          if (is_dec_char(b)) wait_acc = dec_shift_in(wait_acc, b);
          else emit_token();
        end
        default: scan_phase = SEEK_V;
      endcase
    end

    // The end marker closes the buffer, with a verdict if none was given yet.
    if (eob) begin
      if (!token_done) begin
        if (scan_phase >= AFTER_HASH) emit_token();
        else emit_not_found();
      end
      scan_phase = SEEK_V;
      token_done = 1'b0;
      ver_has_digit = 1'b0;
      nib_count = '0;
      upper_nib = '0;
      ver_acc = '0;
      size_acc = '0;
      wait_acc = '0;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Compares the result word on the output channel with the oldest expectation.
  function automatic void check_result();
    scan_result_t exp_r;
    if (pending_results.size() == 0) begin
      $display("%0t: result word with nothing expected: found %0b index %0d hash %h",
               $time, out_if.found, out_if.word_index, out_if.hash_word);
      mismatches++;
      return;
    end
    exp_r = pending_results.pop_front();
    compare_field("found", 64'(exp_r.found), 64'(out_if.found));
    compare_field("version_number", 64'(exp_r.version_number), 64'(out_if.version_number));
    compare_field("image_size", 64'(exp_r.image_size), 64'(out_if.image_size));
    compare_field("wait_time", 64'(exp_r.wait_time), 64'(out_if.wait_time));
    compare_field("hash_word", exp_r.hash_word, out_if.hash_word);
    compare_field("word_index", 64'(exp_r.word_index), 64'(out_if.word_index));
    compare_field("last_result", 64'(exp_r.last_result), 64'(out_if.last_result));
    if (exp_r.found) found_seen++;
    else not_found_seen++;
  endfunction

  // Output side: checks each accepted word, then picks ready for the next edge.
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) check_result();
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offers one input word after a random gap and waits until it is taken.
  task automatic send_word(input logic [BYTE_W-1:0] b, input logic eob);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.end_of_buffer <= eob;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (!token_done) parsed_words++;
    words_sent++;
    predict_word(b, eob);
  endtask

  // Sends the buffer under construction, end marker on its last word.
  task automatic send_frame();
    int n;
    n = frame_q.size();
    for (int i = 0; i < n; i++) send_word(frame_q[i], i == n - 1);
    frame_q.delete();
    buffers_sent++;
  endtask

  // Stops offering words until every owed result word has come back.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_0 + {4'd0, n} : CH_A_LC + {4'd0, n} - 8'd10;
  endfunction

  // Appends the first ndig hex digits of token_hash.
  function automatic void push_hash(input int ndig);
    logic [BYTE_W-1:0] hb;
    for (int i = 0; i < ndig; i++) begin
      hb = token_hash[i / 2];
      frame_q.push_back(hex_char((i % 2 == 0) ? hb[7:4] : hb[3:0]));
    end
  endfunction

  function automatic void push_core(input string ver_txt, input string size_txt,
                                    input int ndig);
    push_text({"V.", ver_txt, ":L.", size_txt, ":H."});
    push_hash(ndig);
  endfunction

  // Hash patterns: 0 random, 1 all ones, 2 all zeros, 3 counting.
  function automatic void fill_hash(input int pattern);
    for (int i = 0; i < HASH_BYTES_DEF; i++) begin
      case (pattern)
        1: token_hash[i] = 8'hFF;
        2: token_hash[i] = 8'h00;
        3: token_hash[i] = 8'(i * 9 + 1);
        default: token_hash[i] = 8'($urandom_range(0, 255));
      endcase
    end
  endfunction

  function automatic string rand_digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  // Mostly short numbers, now and then long enough to saturate.
  function automatic string rand_number_text();
    if ($urandom_range(0, 9) == 0) return rand_digits($urandom_range(11, 14));
    return rand_digits($urandom_range(1, 10));
  endfunction

  // Half fully random bytes, half bytes that the token is made of.
  function automatic logic [BYTE_W-1:0] noise_word();
    string alpha;
    alpha = "V.:LHW0123456789abcdefgA/ ";
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 255));
    return alpha[$urandom_range(0, alpha.len() - 1)];
  endfunction

  // One random buffer: noise, a token with random content, or a damaged token.
  task automatic random_frame();
    int sel;
    int n;
    sel = $urandom_range(0, 99);
    if (sel < 15) begin
      n = $urandom_range(1, 8);
      repeat (n) frame_q.push_back(noise_word());
    end else begin
      repeat ($urandom_range(0, 4)) frame_q.push_back(noise_word());
      fill_hash(0);
      push_core(rand_number_text(), ($urandom_range(0, 9) == 0) ? "" : rand_number_text(),
                2 * HASH_BYTES);
      case ($urandom_range(0, 5))
        1: push_text({":W.", rand_number_text()});
        2: push_text(":W.");
        3: push_text(":W");
        4: push_text(":");
        5: push_text(":x");
        default: ;
      endcase
      repeat ($urandom_range(0, 3)) frame_q.push_back(noise_word());
      if (sel >= 85) begin
        fill_hash(0);
        push_core(rand_number_text(), rand_number_text(), 2 * HASH_BYTES);
        frame_q.push_back(noise_word());
      end
      if (sel < 35) frame_q[$urandom_range(0, frame_q.size() - 1)] = noise_word();
      else if (sel < 50) begin
        n = $urandom_range(1, frame_q.size());
        while (frame_q.size() > n) void'(frame_q.pop_back());
      end
    end
    send_frame();
  endtask

  // Buffers of a single word: nothing can be found.
  task automatic test_lone_end_marker();
    frame_q.push_back(8'h00);
    send_frame();
    frame_q.push_back(8'hFF);
    send_frame();
    frame_q.push_back(CH_V);
    send_frame();
  endtask

  // Complete tokens, and bytes after a match that must be ignored.
  task automatic test_basic_token();
    fill_hash(3);
    push_core("12", "3456", 2 * HASH_BYTES);
    push_text(":W.30");
    send_frame();
    fill_hash(1);
    push_core("0", "0", 2 * HASH_BYTES);
    push_text(" V.1:L.2:H.");
    push_hash(2 * HASH_BYTES);
    push_text(":W.5");
    send_frame();
    fill_hash(2);
    push_core("9", "9", 2 * HASH_BYTES);
    send_frame();
  endtask

  // Missing and broken suffixes, each still closing the token; only the last gives a nonzero wait time.
  task automatic test_suffix_variants();
    string sfx [6];
    sfx = '{":", ":W", ":W.", ":X!", ":Wz", ":W.77x9"};
    for (int i = 0; i < 6; i++) begin
      fill_hash(0);
      push_core("3", "44", 2 * HASH_BYTES);
      push_text(sfx[i]);
      send_frame();
    end
  endtask

  // An empty version breaks the token; an empty size is accepted.
  task automatic test_empty_fields();
    fill_hash(0);
    push_core("", "1", 2 * HASH_BYTES);
    push_core("5", "", 2 * HASH_BYTES);
    push_text("!");
    send_frame();
  endtask

  // Numbers at and beyond the top of 32 bits.
  task automatic test_saturation();
    fill_hash(0);
    push_core("99999999999999999999", "4294967296", 2 * HASH_BYTES);
    push_text(":W.4294967295");
    send_frame();
    fill_hash(0);
    push_core("4294967295", "0000000001", 2 * HASH_BYTES);
    push_text(":W.42949672950;");
    send_frame();
  endtask

  // Bad hex digits, a hash cut short by the end marker, and digit boundaries.
  task automatic test_bad_hex_and_cutoff();
    fill_hash(0);
    push_core("5", "5", 20);
    push_text("A0123");
    send_frame();
    push_core("5", "5", 33);
    push_text("g");
    send_frame();
    push_core("7", "7", 2 * HASH_BYTES - 1);
    send_frame();
    push_text("V./:L.1V.3/V.4:L.5;");
    send_frame();
  endtask

  // A failing 'V' starts the next attempt at once.
  task automatic test_restart_on_v();
    fill_hash(0);
    push_text("VV.3:L.4:H.");
    push_hash(2 * HASH_BYTES);
    push_text(";");
    send_frame();
    fill_hash(0);
    push_text("V.1:LV.2:L.5:H.");
    push_hash(2 * HASH_BYTES);
    send_frame();
    fill_hash(0);
    push_text("V.6:L.6:H.abV.8:L.8:H.");
    push_hash(2 * HASH_BYTES);
    push_text("W");
    send_frame();
    push_text("V.12:L");
    send_frame();
  endtask

  // Long hold-off at the output while tokens keep coming, then a full drain.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 3; i++) begin
      fill_hash(0);
      push_core(rand_number_text(), rand_number_text(), 2 * HASH_BYTES);
      push_text(":W.1");
      send_frame();
    end
    wait_drained();
    fill_hash(0);
    push_core("1", "2", 2 * HASH_BYTES);
    send_frame();
  endtask

  task automatic test_random_traffic(input int word_goal, input int result_goal,
                                     input int send_pct, input int recv_pct);
    int words_at_start;
    int results_at_start;
    words_at_start = parsed_words;
    results_at_start = results_predicted;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while ((parsed_words - words_at_start) < word_goal ||
           (results_predicted - results_at_start) < result_goal) begin
      random_frame();
    end
  endtask

  initial begin
    int waited;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data_byte <= '0;
    in_if.end_of_buffer <= 1'b0;
    send_idle_pct = 26;
    recv_idle_pct = 82;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_lone_end_marker();
    test_basic_token();
    test_suffix_variants();
    test_empty_fields();
    test_saturation();
    test_bad_hex_and_cutoff();
    test_restart_on_v();
    test_backpressure();
    test_random_traffic(170, 20, 26, 82);
    test_random_traffic(170, 20, 82, 26);
    test_random_traffic(170, 20, 0, 0);

    // Let the last result words come out, then watch for stray ones.
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, pending_results.size());
      mismatches += pending_results.size();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d buffers, %0d input words (%0d parsed before a match)",
             buffers_sent, words_sent, parsed_words);
    $display("checked %0d found and %0d not-found result words under stalls and hold-off",
             found_seen, not_found_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/vts_pkg.sv
hw/rtl/vts_ifs.sv
hw/rtl/version_token_scanner_unit.sv
hw/rtl/vts_checker.sv
verif/tb_top.sv
